/* rtl/tsss_pkg.sv */
package tsss_pkg;

  localparam int DIGIT_COUNT = 3;
  localparam int DEG_W = 10;
  localparam int POS_W = 2;
  localparam int MV_W = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic ACTION_READING = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic                   action;
    logic signed [MV_W-1:0] reading_mv;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       digit_select;
    logic [7:0]       segments;
    logic [DEG_W-1:0] shown_degrees;
  } out_item_t;

  typedef struct packed {
    logic [DEG_W-1:0] degrees;
    logic [POS_W-1:0] position;
  } work_t;

  function automatic logic [POS_W-1:0] significant_digits(input logic [DEG_W-1:0] value);
    logic [POS_W-1:0] count;
    count = POS_W'(1);
    if (value >= DEG_W'(10)) count = POS_W'(2);
    if (value >= DEG_W'(100)) count = POS_W'(3);
    if (count > POS_W'(DIGIT_COUNT)) count = POS_W'(DIGIT_COUNT);
    return count;
  endfunction

  function automatic logic [7:0] segment_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0: pat = 8'h03;
      4'd1: pat = 8'h9f;
      4'd2: pat = 8'h25;
      4'd3: pat = 8'h0d;
      4'd4: pat = 8'h99;
      4'd5: pat = 8'h49;
      4'd6: pat = 8'h41;
      4'd7: pat = 8'h1f;
      4'd8: pat = 8'h01;
      4'd9: pat = 8'h09;
      default: pat = 8'h03;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] segment_drive(input logic [3:0] digit);
    logic [7:0] pat;
    logic [7:0] drive;
    pat = segment_pattern(digit);
    for (int i = 0; i < 8; i++) begin
      drive[i] = ~pat[7-i];
    end
    return drive;
  endfunction

endpackage

/* rtl/tsss_front.sv */
module tsss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tsss_pkg::in_item_t  item,
  output logic                q_push,
  input  logic                q_full,
  output tsss_pkg::work_t     q_data
);

  logic [tsss_pkg::DEG_W-1:0] degrees;
  logic [tsss_pkg::DEG_W-1:0] degrees_next;
  logic [tsss_pkg::POS_W-1:0] position;
  logic [tsss_pkg::POS_W-1:0] position_next;
  logic [10:0]                diff;
  logic [22:0]                prod;
  logic [tsss_pkg::DEG_W-1:0] deg_conv;
  logic [tsss_pkg::POS_W:0]   step;
  logic                       accept;

  assign full = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    diff = 11'(item.reading_mv - 12'sd495);
    prod = 23'(diff) * 23'd3277;
    if (item.reading_mv >= 12'sd495) begin
      deg_conv = tsss_pkg::DEG_W'(prod[22:15]);
    end else begin
      deg_conv = '0;
    end
    step = {1'b0, position} + 3'd1;
    if (item.action == tsss_pkg::ACTION_READING) begin
      degrees_next = deg_conv;
      position_next = '0;
    end else begin
      degrees_next = degrees;
      if (step >= {1'b0, tsss_pkg::significant_digits(degrees)}) begin
        position_next = '0;
      end else begin
        position_next = step[tsss_pkg::POS_W-1:0];
      end
    end
    q_data.degrees = degrees_next;
    q_data.position = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degrees <= '0;
      position <= '0;
    end else if (accept) begin
      degrees <= degrees_next;
      position <= position_next;
    end
  end

endmodule

/* rtl/tsss_queue.sv */
module tsss_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tsss_pkg::work_t wdata,
  input  logic            pop,
  output logic            empty,
  output tsss_pkg::work_t rdata
);

  tsss_pkg::work_t             entries [tsss_pkg::QUEUE_DEPTH];
  logic [tsss_pkg::QPTR_W-1:0] wr_ptr;
  logic [tsss_pkg::QPTR_W-1:0] rd_ptr;
  logic [tsss_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign full = (count == tsss_pkg::QCNT_W'(tsss_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + tsss_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - tsss_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tsss_back.sv */
module tsss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  tsss_pkg::work_t     q_data,
  output logic                empty,
  input  logic                pop,
  output tsss_pkg::out_item_t result
);

  logic                       valid;
  logic                       take;
  logic [17:0]                p1;
  logic [15:0]                p2;
  logic [6:0]                 q1;
  logic [3:0]                 q2;
  logic [tsss_pkg::DEG_W-1:0] units_full;
  logic [6:0]                 tens_full;
  logic [3:0]                 digit;
  logic [tsss_pkg::POS_W-1:0] pos;
  tsss_pkg::out_item_t        result_next;

  assign empty = !valid;
  assign take = !q_empty && (!valid || pop);
  assign q_pop = take;

  always_comb begin
    p1 = 18'(q_data.degrees) * 18'd205;
    p2 = 16'(q_data.degrees) * 16'd41;
    q1 = p1[17:11];
    q2 = p2[15:12];
    units_full = q_data.degrees - tsss_pkg::DEG_W'({q1, 3'b000})
                 - tsss_pkg::DEG_W'({q1, 1'b0});
    tens_full = q1 - 7'({q2, 3'b000}) - 7'({q2, 1'b0});
    pos = (q_data.position > 2'd2) ? '0 : q_data.position;
    unique case (pos)
      2'd1: digit = tens_full[3:0];
      2'd2: digit = (q2 >= 4'd10) ? q2 - 4'd10 : q2;
      default: digit = units_full[3:0];
    endcase
    result_next.digit_select = 3'b100 >> pos;
    result_next.segments = tsss_pkg::segment_drive(digit);
    result_next.shown_degrees = q_data.degrees;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/temperature_seven_segment_scanner_core.sv */
// Each accepted item is written into a queue entry and then into the result register.
// Throughput: one item per cycle while the queue is not full; the front updates the
// stored value and scan position, and a two-entry queue feeds the digit decode stage.
// Reset (rst, synchronous, active high) clears the value to zero, the scan to
// the units digit, and empties both the queue and the result register.
module temperature_seven_segment_scanner_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tsss_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output tsss_pkg::out_item_t result
);

  logic            fq_push;
  logic            fq_full;
  tsss_pkg::work_t fq_wdata;
  logic            bq_pop;
  logic            bq_empty;
  tsss_pkg::work_t bq_rdata;

  tsss_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_wdata)
  );

  tsss_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wdata),
    .pop   (bq_pop),
    .empty (bq_empty),
    .rdata (bq_rdata)
  );

  tsss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (bq_empty),
    .q_pop   (bq_pop),
    .q_data  (bq_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

/* tb/tb_temperature_seven_segment_scanner_core.sv */
`timescale 1ns / 100ps

module tb_temperature_seven_segment_scanner_core;
  import tsss_pkg::*;

  localparam int RANDOM_STEPS = 1030;
  localparam int STEADY_TAIL = 150;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] GLYPH [10] = '{
    8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1f, 8'h01, 8'h09
  };

  typedef struct {
    logic             action;
    logic signed [11:0] mv;
    bit               typed;
    out_item_t        want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  in_item_t item;
  logic empty;
  logic pop;
  out_item_t result;

  logic [DEG_W-1:0] model_degrees;
  logic [POS_W-1:0] model_position;
  out_item_t pending_display [$];
  step_row_t bench_rows [$];

  bit steady;
  bit stim_typed;
  out_item_t stim_want;
  int in_count;
  int mismatches;
  int idle_cycles;

  temperature_seven_segment_scanner_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t advance_display(in_item_t it);
    int mv;
    int deg;
    int span;
    int shown_pos;
    int place;
    int digit;
    out_item_t o;
    if (it.action == ACTION_READING) begin
      mv = int'(it.reading_mv);
      deg = (mv >= 495) ? (mv - 495) / 10 : 0;
      if (deg > 999) deg = 999;
      model_degrees = DEG_W'(deg);
      model_position = '0;
    end else begin
      span = (model_degrees >= 100) ? 3 : (model_degrees >= 10) ? 2 : 1;
      if (span > DIGIT_COUNT) span = DIGIT_COUNT;
      if (int'(model_position) + 1 >= span) begin
        model_position = '0;
      end else begin
        model_position = model_position + POS_W'(1);
      end
    end
    shown_pos = (model_position > 2) ? 0 : int'(model_position);
    place = (shown_pos == 2) ? 100 : (shown_pos == 1) ? 10 : 1;
    digit = (int'(model_degrees) / place) % 10;
    o.digit_select = 3'b100 >> shown_pos;
    for (int i = 0; i < 8; i++) begin
      o.segments[i] = ~GLYPH[digit][7-i];
    end
    o.shown_degrees = model_degrees;
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && pop && !empty) begin
      got = result;
      if (pending_display.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: sel=%b seg=%h deg=%0d",
                   got.digit_select, got.segments, got.shown_degrees);
        end
      end else begin
        want = pending_display.pop_front();
        if (got.digit_select !== want.digit_select || got.segments !== want.segments ||
            got.shown_degrees !== want.shown_degrees) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected sel=%b seg=%h deg=%0d, got sel=%b seg=%h deg=%0d",
                     want.digit_select, want.segments, want.shown_degrees,
                     got.digit_select, got.segments, got.shown_degrees);
          end
        end
      end
    end
    if (!rst && push && !full) begin
      want = advance_display(item);
      pending_display.push_back(stim_typed ? stim_want : want);
      in_count <= in_count + 1;
    end
    if ((!rst && push && !full) || (!rst && pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_temperature_seven_segment_scanner_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_row(logic action, int mv, bit typed, logic [2:0] sel,
                         logic [7:0] seg, int deg);
    step_row_t r;
    r.action = action;
    r.mv = 12'(mv);
    r.typed = typed;
    r.want.digit_select = sel;
    r.want.segments = seg;
    r.want.shown_degrees = DEG_W'(deg);
    bench_rows.push_back(r);
  endtask

  task automatic send_step(in_item_t it, bit typed, out_item_t want);
    int seen;
    if (!steady && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    item <= it;
    stim_typed <= typed;
    stim_want <= want;
    push <= 1'b1;
    seen = in_count;
    do @(negedge clk); while (in_count == seen);
  endtask

  function automatic in_item_t random_step();
    in_item_t it;
    int pick;
    int center;
    it.action = ($urandom_range(0, 99) < 55) ? ACTION_TICK : ACTION_READING;
    it.reading_mv = 12'($urandom);
    if (it.action == ACTION_READING) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        it.reading_mv = 12'($urandom_range(495, 2047));
      end else if (pick < 8) begin
        case ($urandom_range(0, 2))
          0: center = 495;
          1: center = 595;
          default: center = 1495;
        endcase
        it.reading_mv = 12'(center + $urandom_range(0, 20) - 10);
      end
    end
    return it;
  endfunction

  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  initial begin
    in_item_t it;
    out_item_t none;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    stim_typed = 1'b0;
    stim_want = '0;
    steady = 1'b0;
    in_count = 0;
    mismatches = 0;
    idle_cycles = 0;
    model_degrees = '0;
    model_position = '0;
    none = '0;

    add_row(ACTION_TICK, 0, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, -2048, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, 494, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, -1, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, 495, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_TICK, -1, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, 504, 1, 3'b100, 8'h3f, 0);
    add_row(ACTION_READING, 505, 1, 3'b100, 8'h06, 1);
    add_row(ACTION_TICK, 0, 1, 3'b100, 8'h06, 1);
    add_row(ACTION_READING, 2047, 1, 3'b100, 8'h6d, 155);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_TICK, 2047, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_READING, 594, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_READING, 595, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_READING, 1494, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_READING, 1495, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_TICK, 0, 0, '0, '0, 0);
    add_row(ACTION_READING, 1365, 0, '0, '0, 0);

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (bench_rows[i]) begin
      it.action = bench_rows[i].action;
      it.reading_mv = bench_rows[i].mv;
      send_step(it, bench_rows[i].typed, bench_rows[i].want);
    end

    for (int n = 0; n < RANDOM_STEPS; n++) begin
      if (n == RANDOM_STEPS - STEADY_TAIL) steady = 1'b1;
      send_step(random_step(), 1'b0, none);
    end

    push <= 1'b0;
    while (pending_display.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_temperature_seven_segment_scanner_core: clean");
    end else begin
      $display("tb_temperature_seven_segment_scanner_core: errors");
    end
    $finish;
  end

endmodule
